@@ sv/apg_pkg.sv @@
// ----------------------------------------------------------------------------
// Arc point generator package
// Shared types, CORDIC constants and the controller/datapath interface.
// ----------------------------------------------------------------------------
package apg_pkg;

  localparam int CordicIters = 16;
  localparam int DivSteps    = 24;
  localparam logic signed [32:0] CordicGainInv = 33'sd652032874;

  typedef struct packed {
    logic       load;
    logic       div_init;
    logic       div_step;
    logic       cor_init;
    logic       cor_step;
    logic [3:0] iter;
    logic       mul;
    logic       sum;
    logic       next_point;
  } apg_cmd_t;

  typedef struct packed {
    logic last_point;
  } apg_stat_t;

  function automatic logic signed [31:0] atan_lut(input logic [3:0] idx);
    logic signed [31:0] v;
    case (idx)
      4'd0:    v = 32'sh20000000;
      4'd1:    v = 32'sh12E4051E;
      4'd2:    v = 32'sh09FB385B;
      4'd3:    v = 32'sh051111D4;
      4'd4:    v = 32'sh028B0D43;
      4'd5:    v = 32'sh0145D7E1;
      4'd6:    v = 32'sh00A2F61E;
      4'd7:    v = 32'sh00517C55;
      4'd8:    v = 32'sh0028BE53;
      4'd9:    v = 32'sh00145F2F;
      4'd10:   v = 32'sh000A2F98;
      4'd11:   v = 32'sh000517CC;
      4'd12:   v = 32'sh00028BE6;
      4'd13:   v = 32'sh000145F3;
      4'd14:   v = 32'sh0000A2FA;
      4'd15:   v = 32'sh0000517D;
      default: v = 32'sh0;
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
    logic signed [33:0] t;
    logic signed [18:0] r;
    t = 34'(v) + 34'sd16384;
    r = 19'(t >>> 15);
    if (r > 19'sd32767) begin
      return 16'sd32767;
    end else if (r < -19'sd32768) begin
      return -16'sd32768;
    end
    return r[15:0];
  endfunction

endpackage

@@ sv/apg_ctrl.sv @@
// ----------------------------------------------------------------------------
// Arc point generator controller
// Sequences division, CORDIC rotation, scaling and output for each point.
// ----------------------------------------------------------------------------
module apg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output apg_pkg::apg_cmd_t  cmd,
  input  apg_pkg::apg_stat_t stat
);
  import apg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DINIT = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CINIT = 3'd3;
  localparam logic [2:0] S_ROT   = 3'd4;
  localparam logic [2:0] S_MUL   = 3'd5;
  localparam logic [2:0] S_SUM   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.iter  = cnt_r[3:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(DivSteps - 1)) begin
          state_nxt = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.cor_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_ROT;
      end
      S_ROT: begin
        cmd.cor_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(CordicIters - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (stat.last_point) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.next_point = 1'b1;
            state_nxt      = S_DINIT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ sv/apg_datapath.sv @@
// ----------------------------------------------------------------------------
// Arc point generator datapath
// Angle interpolation divider, iterative CORDIC, scaling and saturation.
// ----------------------------------------------------------------------------
module apg_datapath #(
  parameter int MAX_STEPS  = 63,
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  apg_pkg::apg_cmd_t   cmd,
  output apg_pkg::apg_stat_t  stat,
  input  logic signed [15:0]  in_origin_x,
  input  logic signed [15:0]  in_origin_y,
  input  logic [11:0]         in_radius,
  input  logic [15:0]         in_start_angle,
  input  logic [16:0]         in_end_angle,
  input  logic [5:0]          in_point_count,
  output logic signed [15:0]  out_point_x,
  output logic signed [15:0]  out_point_y,
  output logic [5:0]          out_point_index,
  output logic                out_last
);
  import apg_pkg::*;

  localparam logic signed [33:0] CoordHi = (34'sd1 <<< (COORD_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] CoordLo = -CoordHi - 34'sd1;

  logic signed [15:0] ox_r, oy_r;
  logic [11:0]        rad_r;
  logic [15:0]        st_r;
  logic               dneg_r;
  logic [16:0]        dmag_r;
  logic [5:0]         n_r, idx_r;
  logic [22:0]        mag_r;
  logic [23:0]        num_r, quo_r;
  logic [7:0]         rem_r;
  logic signed [32:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [1:0]         quad_r;
  logic signed [28:0] px_r, py_r;
  logic signed [15:0] ptx_r, pty_r;

  logic signed [17:0] diff;
  logic [5:0]         n_sat;
  logic [7:0]         trial_sh;
  logic [7:0]         dvsr;
  logic signed [24:0] off, ang_sum;
  logic [31:0]        phase;
  logic signed [32:0] dx, dy, xq, yq;
  logic signed [15:0] cq, sq;

  assign diff  = $signed({1'b0, in_end_angle}) - $signed({2'b0, in_start_angle});
  assign n_sat = (in_point_count > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : in_point_count;

  assign dvsr     = {1'b0, n_r, 1'b0};
  assign trial_sh = {rem_r[6:0], num_r[23]};

  always_comb begin
    if (n_r == 6'd0) begin
      off = '0;
    end else if (dneg_r) begin
      off = -$signed({1'b0, quo_r});
    end else begin
      off = $signed({1'b0, quo_r});
    end
  end
  assign ang_sum = $signed({9'b0, st_r}) + off;
  assign phase   = {ang_sum[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}};

  assign dx = y_r >>> cmd.iter;
  assign dy = x_r >>> cmd.iter;

  always_comb begin
    case (quad_r)
      2'd1: begin
        xq = -y_r;
        yq = x_r;
      end
      2'd2: begin
        xq = -x_r;
        yq = -y_r;
      end
      2'd3: begin
        xq = y_r;
        yq = -x_r;
      end
      default: begin
        xq = x_r;
        yq = y_r;
      end
    endcase
  end
  assign cq = to_q15(xq);
  assign sq = to_q15(yq);

  function automatic logic signed [15:0] place(input logic signed [15:0] org,
                                               input logic signed [28:0] prod);
    logic signed [28:0] adj;
    logic signed [13:0] q;
    logic signed [33:0] s;
    adj = (prod < 0) ? prod + 29'sd32767 : prod;
    q   = 14'(adj >>> 15);
    s   = 34'(org) + 34'(q);
    if (s > CoordHi) begin
      s = CoordHi;
    end else if (s < CoordLo) begin
      s = CoordLo;
    end
    return s[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ox_r   <= in_origin_x;
      oy_r   <= in_origin_y;
      rad_r  <= in_radius;
      st_r   <= in_start_angle;
      dneg_r <= diff[17];
      dmag_r <= diff[17] ? 17'(-diff) : diff[16:0];
      n_r    <= n_sat;
      idx_r  <= '0;
      mag_r  <= '0;
    end
    if (cmd.next_point) begin
      idx_r <= idx_r + 6'd1;
      mag_r <= mag_r + 23'(dmag_r);
    end
    if (cmd.div_init) begin
      num_r <= {mag_r, 1'b0} + 24'(n_r);
      rem_r <= '0;
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      num_r <= {num_r[22:0], 1'b0};
      if (trial_sh >= dvsr) begin
        rem_r <= trial_sh - dvsr;
        quo_r <= {quo_r[22:0], 1'b1};
      end else begin
        rem_r <= trial_sh;
        quo_r <= {quo_r[22:0], 1'b0};
      end
    end
    if (cmd.cor_init) begin
      x_r    <= CordicGainInv;
      y_r    <= '0;
      z_r    <= $signed({2'b0, phase[29:0]});
      quad_r <= phase[31:30];
    end
    if (cmd.cor_step) begin
      if (z_r >= 0) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_lut(cmd.iter);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_lut(cmd.iter);
      end
    end
    if (cmd.mul) begin
      px_r <= $signed({1'b0, rad_r}) * cq;
      py_r <= $signed({1'b0, rad_r}) * sq;
    end
    if (cmd.sum) begin
      ptx_r <= place(ox_r, px_r);
      pty_r <= place(oy_r, py_r);
    end
  end

  assign stat.last_point = (idx_r == n_r);
  assign out_point_x     = ptx_r;
  assign out_point_y     = pty_r;
  assign out_point_index = idx_r;
  assign out_last        = (idx_r == n_r);

endmodule

@@ sv/arc_point_generator.sv @@
// ----------------------------------------------------------------------------
// Arc point generator
// A new request is accepted only once every point of the previous request
// has been transferred. The points are computed one at a time by the 24-step
// serial divider and the 16-iteration shared CORDIC rotator.
// Reset: synchronous active-low rst_n returns the controller to idle.
// ----------------------------------------------------------------------------
module arc_point_generator #(
  parameter int MAX_STEPS  = 63,
  parameter int ANGLE_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [11:0]        in_radius,
  input  logic [15:0]        in_start_angle,
  input  logic [16:0]        in_end_angle,
  input  logic [5:0]         in_point_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_point_x,
  output logic signed [15:0] out_point_y,
  output logic [5:0]         out_point_index,
  output logic               out_last
);
  import apg_pkg::*;

  apg_cmd_t  cmd;
  apg_stat_t stat;

  apg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  apg_datapath #(
    .MAX_STEPS  (MAX_STEPS),
    .ANGLE_BITS (ANGLE_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .stat            (stat),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_radius       (in_radius),
    .in_start_angle  (in_start_angle),
    .in_end_angle    (in_end_angle),
    .in_point_count  (in_point_count),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_index (out_point_index),
    .out_last        (out_last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready while a point is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (!in_ready && !out_valid))
    else $error("request transfer did not start work");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("not idle after final point");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (out_point_index == 6'd0))
    else $error("point index not cleared on new request");

endmodule

@@ dv/arc_point_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc point checker
// Watches the request and point channels, computes the expected arc points
// for every request transfer and compares each point transfer, field by field,
// with the oldest expected point.
// ----------------------------------------------------------------------------
module arc_point_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [11:0]        in_radius,
  input  logic [15:0]        in_start_angle,
  input  logic [16:0]        in_end_angle,
  input  logic [5:0]         in_point_count,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] out_point_x,
  input  logic signed [15:0] out_point_y,
  input  logic [5:0]         out_point_index,
  input  logic               out_last,
  output int                 fail_count,
  output int                 points_pending
);

  localparam int MaxSteps = 63;

  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [5:0]         index;
    logic               last;
  } arc_point_t;

  arc_point_t expected_points[$];

  const longint atan_steps[16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  function automatic longint round_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint clamp_coord(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic rotate_unit(input logic [15:0] angle, output longint c, output longint s);
    longint x, y, z, dx, dy, t;
    logic [31:0] phase;
    phase = {angle, 16'h0};
    z = longint'(phase[29:0]);
    x = 652032874;
    y = 0;
    for (int k = 0; k < 16; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_steps[k];
      end else begin
        x += dx; y -= dy; z += atan_steps[k];
      end
    end
    case (phase[31:30])
      2'd1: begin t = x; x = -y; y = t; end
      2'd2: begin x = -x; y = -y; end
      2'd3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    c = round_q15(x);
    s = round_q15(y);
  endtask

  task automatic tessellate_arc();
    longint ox, oy, r, st, diff, n, num, mag, off, c, s;
    arc_point_t p;
    ox = in_origin_x;
    oy = in_origin_y;
    r = in_radius;
    st = in_start_angle;
    diff = longint'(in_end_angle) - st;
    n = in_point_count;
    if (n > MaxSteps) n = MaxSteps;
    for (longint i = 0; i <= n; i++) begin
      off = 0;
      if (n > 0) begin
        num = i * diff;
        mag = num < 0 ? -num : num;
        off = (2 * mag + n) / (2 * n);
        if (num < 0) off = -off;
      end
      rotate_unit(16'(st + off), c, s);
      p.px = 16'(clamp_coord(ox + (r * c) / 32768));
      p.py = 16'(clamp_coord(oy + (r * s) / 32768));
      p.index = 6'(i);
      p.last = (i == n);
      expected_points.push_back(p);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign points_pending = expected_points.size();

  always @(posedge clk) begin
    arc_point_t e;
    if (rst_n) begin
      if (in_valid && in_ready) tessellate_arc();
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("point transfer with no point expected");
        end else begin
          e = expected_points.pop_front();
          if (out_point_x !== e.px)
            report_mismatch($sformatf("x %0d, expected %0d", out_point_x, e.px));
          if (out_point_y !== e.py)
            report_mismatch($sformatf("y %0d, expected %0d", out_point_y, e.py));
          if (out_point_index !== e.index)
            report_mismatch($sformatf("index %0d, expected %0d", out_point_index, e.index));
          if (out_last !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_last, e.last));
        end
      end
    end
  end

endmodule

@@ dv/arc_point_generator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Arc point generator testbench
// Sends directed and random arc requests with random gaps on both channels;
// a checker beside the block predicts every point and compares the output.
// ----------------------------------------------------------------------------
module arc_point_generator_tb;

  localparam int IdleLimit = 20000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_origin_x;
  logic signed [15:0] in_origin_y;
  logic [11:0]        in_radius;
  logic [15:0]        in_start_angle;
  logic [16:0]        in_end_angle;
  logic [5:0]         in_point_count;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_point_x;
  logic signed [15:0] out_point_y;
  logic [5:0]         out_point_index;
  logic               out_last;
  int                 fail_count;
  int                 points_pending;
  int                 idle_cycles;

  arc_point_generator dut (.*);
  arc_point_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int random_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic send_arc(input logic [15:0] ox, input logic [15:0] oy, input logic [11:0] r,
                          input logic [15:0] st, input logic [16:0] en, input logic [5:0] n);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_origin_x    <= ox;
    in_origin_y    <= oy;
    in_radius      <= r;
    in_start_angle <= st;
    in_end_angle   <= en;
    in_point_count <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_arc();
    logic [5:0] n;
    logic [11:0] r;
    n = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, 8)) : 6'($urandom);
    r = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(4000, 4095)) : 12'($urandom);
    send_arc(16'($urandom), 16'($urandom), r, 16'($urandom), 17'($urandom), n);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 9) < 6) ? 1'b1 : ($urandom_range(0, 19) == 0 ? 1'b0 :
                 1'($urandom));
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_origin_x    = '0;
    in_origin_y    = '0;
    in_radius      = '0;
    in_start_angle = '0;
    in_end_angle   = '0;
    in_point_count = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_arc(16'h0000, 16'h0000, 12'd100, 16'd0, 17'd16384, 6'd0);
    send_arc(16'h0000, 16'h0000, 12'd4095, 16'd0, 17'd65536, 6'd4);
    send_arc(16'h7FFF, 16'h7FFF, 12'd4095, 16'd0, 17'd16384, 6'd2);
    send_arc(16'h8000, 16'h8000, 12'd4095, 16'd32768, 17'd49152, 6'd2);
    send_arc(16'h7F00, 16'h80FF, 12'd4095, 16'd65535, 17'd131071, 6'd63);
    send_arc(16'h1234, 16'hEDCB, 12'd0, 16'hFFFF, 17'd0, 6'd63);
    send_arc(16'h0000, 16'h0000, 12'd2048, 16'd60000, 17'd100, 6'd8);
    send_arc(16'h0000, 16'h0000, 12'd1000, 16'd0, 17'd3, 6'd2);
    send_arc(16'h0000, 16'h0000, 12'd1000, 16'd10, 17'd7, 6'd2);
    send_arc(16'h0000, 16'h0000, 12'd4095, 16'd8192, 17'd8192, 6'd3);
    send_arc(16'hAAAA, 16'h5555, 12'hAAA, 16'hAAAA, 17'h15555, 6'h2A);
    send_arc(16'h5555, 16'hAAAA, 12'h555, 16'h5555, 17'h0AAAA, 6'h15);
    send_arc(16'h0001, 16'hFFFF, 12'd1, 16'd49152, 17'd131071, 6'd1);

    in_valid <= 1'b0;
    @(posedge clk);
    wait (points_pending == 0);
    send_random_arc();

    for (int k = 0; k < 355; k++) send_random_arc();

    in_valid <= 1'b0;
    @(posedge clk);
    wait (points_pending == 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/apg_pkg.sv
sv/apg_ctrl.sv
sv/apg_datapath.sv
sv/arc_point_generator.sv
dv/arc_point_checker.sv
dv/arc_point_generator_tb.sv
